>>> hw/rtl/cflw_pkg.sv
// Shared types and constants of the complement frame checker with link watch.
package cflw_pkg;

    // Item kinds carried on the input tuser
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam int COUNT_W = 7;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'h7f;
    localparam logic [7:0] CHECK_BIAS = 8'h5a;
    localparam logic [7:0] TIMEOUT_RESET = 8'd120;
    localparam logic [7:0] SILENCE_MAX = 8'hff;

    // One result item
    typedef struct packed {
        logic       frame_done;
        logic       frame_ok;
        logic [6:0] display_version;
        logic       display_fault;
        logic [7:0] key_code;
        logic [7:0] miss_count;
        logic       link_lost;
    } result_t;

endpackage

>>> hw/rtl/complement_frame_checker_link_watch_top.sv
// Top level of the complement frame checker with link watch.
//
// Input stream (s_): one item per handshake. s_tuser is the kind (0 = received
// byte, 1 = one-second tick), s_tdata the received byte, s_tlast the end of
// a frame. Each accepted item gives exactly one result item on m_.
// Result stream (m_): m_tlast says the item closed a frame, m_tuser that the
// frame passed its length, checksum and complement checks; m_tdata carries
// the version, fault bit, key code, miss count and link_lost state after the
// item has been applied.
// Each accepted item's result is registered (result or skid register); one item
// per cycle while s_tready is high, set by the single state update per item.
// A two-entry output stage (result register plus skid register) keeps input
// accepted while a result waits; s_tready drops only when both are full.
// The cfg channel writes the link timeout in seconds; cfg_ready is always high.
// Reset (aresetn low, synchronous) empties the output stage, restarts frame
// reception, clears all counters and sets the timeout to 120 seconds.
module complement_frame_checker_link_watch_top #(
    parameter int HALF_LEN = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // last_byte
    input  logic        s_tuser,   // func
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [6:0] display_version, [7] display_fault,
                                   // [15:8] key_code, [23:16] miss_count,
                                   // [24] link_lost, [31:25] zero
    output logic        m_tlast,   // frame_done
    output logic        m_tuser    // frame_ok
);

    cflw_pkg::result_t new_res;
    cflw_pkg::result_t out_reg, out_next;
    cflw_pkg::result_t skid_reg, skid_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic              in_accept, out_take;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign out_take  = out_valid_reg && m_tready;

    cflw_core #(
        .HALF_LEN(HALF_LEN)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid),
        .cfg_data    (cfg_data),
        .in_accept   (in_accept),
        .in_func     (s_tuser),
        .in_rx_byte  (s_tdata),
        .in_last_byte(s_tlast),
        .result      (new_res)
    );

    // Advance the output stage: skid drains first, new items fill the free slot
    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            if (out_take) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_accept) begin
            if (!out_valid_reg || out_take) begin
                out_next       = new_res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = new_res;
                skid_valid_next = 1'b1;
            end
        end else if (out_take) begin
            out_valid_next = 1'b0;
        end
    end

    // Hold valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payloads
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.frame_done;
    assign m_tuser  = out_reg.frame_ok;
    assign m_tdata  = {7'b0, out_reg.link_lost, out_reg.miss_count, out_reg.key_code,
                       out_reg.display_fault, out_reg.display_version};

endmodule

>>> hw/rtl/cflw_core.sv
// Frame checking state, link watch counters and per-item result logic.
module cflw_core #(
    parameter int HALF_LEN = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_data,
    input  logic             in_accept,
    input  logic             in_func,
    input  logic [7:0]       in_rx_byte,
    input  logic             in_last_byte,
    output cflw_pkg::result_t result
);

    localparam logic [cflw_pkg::COUNT_W-1:0] HALF_POS  = cflw_pkg::COUNT_W'(HALF_LEN);
    localparam logic [cflw_pkg::COUNT_W-1:0] CHECK_POS = cflw_pkg::COUNT_W'(2 * HALF_LEN);
    localparam logic [7:0] CHECK_SEED = 8'((2 * HALF_LEN + int'(cflw_pkg::CHECK_BIAS)) % 256);

    logic [7:0]                   timeout_reg;
    logic [cflw_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [7:0]                   check_reg, check_next;
    logic [7:0]                   half_reg [HALF_LEN];
    logic                         comp_good_reg, comp_good_next;
    logic [7:0]                   silence_reg, silence_next;
    logic                         lost_reg, lost_next;
    logic [6:0]                   version_reg, version_next;
    logic                         fault_reg, fault_next;
    logic [7:0]                   key_reg, key_next;
    logic [7:0]                   miss_reg, miss_next;
    logic                         in_first_half, in_second_half, at_check;
    logic                         half_shift;
    logic [7:0]                   shift_in;
    logic                         frame_good, done, ok;

    assign in_first_half  = (count_reg < HALF_POS);
    assign in_second_half = !in_first_half && (count_reg < CHECK_POS);
    assign at_check       = (count_reg == CHECK_POS);

    // Data bytes shift in; during the complement half the store rotates so that
    // the byte to compare sits at entry 0 and the order is restored at the end.
    assign half_shift = in_accept && (in_func == cflw_pkg::FUNC_BYTE)
                        && (in_first_half || in_second_half);
    assign shift_in   = in_first_half ? in_rx_byte : half_reg[0];

    assign frame_good = at_check && (in_rx_byte == check_reg) && comp_good_reg;

    // Next state for one item
    always_comb begin
        count_next     = count_reg;
        check_next     = check_reg;
        comp_good_next = comp_good_reg;
        silence_next   = silence_reg;
        lost_next      = lost_reg;
        version_next   = version_reg;
        fault_next     = fault_reg;
        key_next       = key_reg;
        miss_next      = miss_reg;
        done           = 1'b0;
        ok             = 1'b0;
        if (in_func == cflw_pkg::FUNC_TICK) begin
            if (silence_reg != cflw_pkg::SILENCE_MAX) begin
                silence_next = silence_reg + 8'd1;
            end
            lost_next = (silence_next >= timeout_reg);
        end else begin
            if (in_first_half || in_second_half) begin
                check_next = check_reg - in_rx_byte;
            end
            if (in_second_half && (~in_rx_byte != half_reg[0])) begin
                comp_good_next = 1'b0;
            end
            if (count_reg != cflw_pkg::COUNT_MAX) begin
                count_next = count_reg + 1'b1;
            end
            if (in_last_byte) begin
                done = 1'b1;
                if (frame_good) begin
                    ok           = 1'b1;
                    version_next = half_reg[0][6:0];
                    fault_next   = half_reg[0][7];
                    key_next     = half_reg[1];
                    silence_next = '0;
                end else begin
                    miss_next = miss_reg + 8'd1;
                end
                count_next     = '0;
                check_next     = CHECK_SEED;
                comp_good_next = 1'b1;
            end
        end
    end

    assign result = '{
        frame_done:      done,
        frame_ok:        ok,
        display_version: version_next,
        display_fault:   fault_next,
        key_code:        key_next,
        miss_count:      miss_next,
        link_lost:       lost_next
    };

    // Hold control state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= cflw_pkg::TIMEOUT_RESET;
            count_reg     <= '0;
            check_reg     <= CHECK_SEED;
            comp_good_reg <= 1'b1;
            silence_reg   <= '0;
            lost_reg      <= 1'b0;
            version_reg   <= '0;
            fault_reg     <= 1'b0;
            key_reg       <= '0;
            miss_reg      <= '0;
        end else begin
            if (cfg_we) begin
                timeout_reg <= cfg_data;
            end
            if (in_accept) begin
                count_reg     <= count_next;
                check_reg     <= check_next;
                comp_good_reg <= comp_good_next;
                silence_reg   <= silence_next;
                lost_reg      <= lost_next;
                version_reg   <= version_next;
                fault_reg     <= fault_next;
                key_reg       <= key_next;
                miss_reg      <= miss_next;
            end
        end
    end

    // Data byte store, shift line with no reset
    always_ff @(posedge aclk) begin
        if (half_shift) begin
            for (int i = 0; i < HALF_LEN - 1; i++) begin
                half_reg[i] <= half_reg[i+1];
            end
            half_reg[HALF_LEN-1] <= shift_in;
        end
    end

endmodule

>>> sim/tb_complement_frame_checker_link_watch_top.sv
// Testbench for the complement frame checker with link watch: random frames and ticks.
`timescale 1ns / 100ps

module tb_complement_frame_checker_link_watch_top;

    localparam int HALF_LEN = 2;
    localparam logic [7:0] CHECK_SEED = 8'(2 * HALF_LEN + int'(cflw_pkg::CHECK_BIAS));
    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_CYCLES = 64;

    typedef enum {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_BAD_COMPL,
        FRAME_SHORT,
        FRAME_LONG,
        FRAME_NOISE
    } frame_kind_t;

    // Predicts the status item for every accepted item and checks the results
    class frame_status_board_t;
        logic [cflw_pkg::COUNT_W-1:0] byte_pos;
        logic [7:0]         check_acc;
        logic [7:0]         half_bytes[HALF_LEN];
        logic               compl_match;
        logic [7:0]         silence;
        logic               lost;
        logic [6:0]         version;
        logic               fault;
        logic [7:0]         key;
        logic [7:0]         misses;
        logic [7:0]         timeout;
        cflw_pkg::result_t  pending_status[$];
        int                 errors;
        int                 good_frames;
        int                 rejected_frames;
        int                 ticks_seen;
        int                 lost_raised;
        int                 results_checked;

        function new();
            timeout = cflw_pkg::TIMEOUT_RESET;
            silence = '0;
            lost = 1'b0;
            version = '0;
            fault = 1'b0;
            key = '0;
            misses = '0;
            errors = 0;
            good_frames = 0;
            rejected_frames = 0;
            ticks_seen = 0;
            lost_raised = 0;
            results_checked = 0;
            foreach (half_bytes[i]) half_bytes[i] = '0;
            restart_frame();
        endfunction

        function void restart_frame();
            byte_pos = '0;
            check_acc = CHECK_SEED;
            compl_match = 1'b1;
        endfunction

        function void set_timeout(logic [7:0] value);
            timeout = value;
        endfunction

        function int pending();
            return pending_status.size();
        endfunction

        // Apply one accepted item and queue the status it must produce
        function void note_item(logic kind, logic [7:0] rx, logic last);
            cflw_pkg::result_t status;
            logic [7:0] inverted;
            bit         length_ok;
            bit         sum_ok;
            int         pos;
            status = '0;
            length_ok = 1'b0;
            sum_ok = 1'b0;
            inverted = ~rx;
            pos = int'(byte_pos);
            if (kind == cflw_pkg::FUNC_TICK) begin
                ticks_seen++;
                if (silence != cflw_pkg::SILENCE_MAX) silence++;
                lost = (silence >= timeout);
                if (lost) lost_raised++;
            end else begin
                if (pos < HALF_LEN) begin
                    half_bytes[pos] = rx;
                    check_acc = check_acc - rx;
                end else if (pos < 2 * HALF_LEN) begin
                    if (inverted != half_bytes[pos - HALF_LEN]) compl_match = 1'b0;
                    check_acc = check_acc - rx;
                end else if (pos == 2 * HALF_LEN) begin
                    length_ok = 1'b1;
                    sum_ok = (rx == check_acc);
                end
                if (byte_pos < cflw_pkg::COUNT_MAX) byte_pos++;
                if (last) begin
                    status.frame_done = 1'b1;
                    if (length_ok && sum_ok && compl_match) begin
                        status.frame_ok = 1'b1;
                        version = half_bytes[0][6:0];
                        fault = half_bytes[0][7];
                        key = half_bytes[1];
                        silence = '0;
                        good_frames++;
                    end else begin
                        misses = misses + 8'd1;
                        rejected_frames++;
                    end
                    restart_frame();
                end
            end
            status.display_version = version;
            status.display_fault = fault;
            status.key_code = key;
            status.miss_count = misses;
            status.link_lost = lost;
            pending_status.push_back(status);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // Compare one result item with the oldest expected status
        function void check_status(logic [31:0] data, logic last, logic user);
            cflw_pkg::result_t want;
            if (pending_status.size() == 0) begin
                $error("result item with no expected status: data 0x%0h", data);
                errors++;
                return;
            end
            want = pending_status.pop_front();
            results_checked++;
            compare_field("frame_done", 8'(want.frame_done), 8'(last));
            compare_field("frame_ok", 8'(want.frame_ok), 8'(user));
            compare_field("display_version", 8'(want.display_version), 8'(data[6:0]));
            compare_field("display_fault", 8'(want.display_fault), 8'(data[7]));
            compare_field("key_code", want.key_code, data[15:8]);
            compare_field("miss_count", want.miss_count, data[23:16]);
            compare_field("link_lost", 8'(want.link_lost), 8'(data[24]));
            compare_field("tdata padding", 8'h00, 8'(data[31:25]));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rx_byte
    logic        s_tlast;   // last_byte
    logic        s_tuser;   // func
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [6:0] version, [7] fault, [15:8] key, [23:16] misses, [24] lost
    logic        m_tlast;   // frame_done
    logic        m_tuser;   // frame_ok

    frame_status_board_t board;
    int  items_sent;
    int  quiet_cycles;
    bit  gaps_on;
    bit  sink_stalls;
    int  hold_requests;
    int  holds_served;
    logic [7:0] mid_timeout;

    complement_frame_checker_link_watch_top #(
        .HALF_LEN(HALF_LEN)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Free-running clock
    always #4 aclk = ~aclk;

    // Note accepted items and check result items at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_item(s_tuser, s_tdata, s_tlast);
            if (m_tvalid && m_tready) board.check_status(m_tdata, m_tlast, m_tuser);
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("complement_frame_checker_link_watch_top test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result receiver: random stall bursts, plus long hold-offs on request
    initial begin : result_sink
        m_tready = 1'b0;
        holds_served = 0;
        forever begin
            @(negedge aclk);
            if (hold_requests != holds_served) begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one item and hold it until accepted; returns at a falling edge
    task automatic send_item(input logic kind, input logic [7:0] value, input logic last);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= value;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    // Sender idle burst
    task automatic gap();
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
    endtask

    task automatic send_tick();
        send_item(cflw_pkg::FUNC_TICK, 8'($urandom), 1'($urandom));
        gap();
    endtask

    // Build and send one frame of the given kind
    task automatic send_frame(input frame_kind_t kind, input logic [7:0] b0,
                              input logic [7:0] b1, input int extra, input bit mid_ticks);
        logic [7:0] frame_bytes[$];
        logic [7:0] sum;
        int         k;
        int         keep;
        sum = CHECK_SEED;
        for (k = 0; k < HALF_LEN; k++)
            frame_bytes.push_back(k == 0 ? b0 : (k == 1 ? b1 : 8'($urandom)));
        for (k = 0; k < HALF_LEN; k++)
            frame_bytes.push_back(~frame_bytes[k]);
        // Corrupt a complement byte but keep the checksum consistent
        if (kind == FRAME_BAD_COMPL) begin
            k = $urandom_range(HALF_LEN, 2 * HALF_LEN - 1);
            frame_bytes[k] = frame_bytes[k] ^ 8'($urandom_range(1, 255));
        end
        foreach (frame_bytes[i]) sum = sum - frame_bytes[i];
        frame_bytes.push_back(sum);
        if (kind == FRAME_BAD_SUM)
            frame_bytes[2 * HALF_LEN] = sum ^ 8'($urandom_range(1, 255));
        if (kind == FRAME_SHORT) begin
            keep = $urandom_range(1, 2 * HALF_LEN);
            while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
        end
        if (kind == FRAME_LONG)
            repeat (extra) frame_bytes.push_back(8'($urandom));
        if (kind == FRAME_NOISE) begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom));
        end
        for (k = 0; k < frame_bytes.size(); k++) begin
            if (mid_ticks && $urandom_range(0, 15) == 0) send_tick();
            send_item(cflw_pkg::FUNC_BYTE, frame_bytes[k], k == frame_bytes.size() - 1);
            gap();
        end
    endtask

    // Pause the sender until every expected status has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_timeout(input logic [7:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.set_timeout(value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed frames with random content, some broken ones and ticks
    task automatic run_traffic(input int count);
        int          stop_at;
        int          pick;
        frame_kind_t kind;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                repeat ($urandom_range(1, 6)) send_tick();
            end else begin
                if (pick < 60)      kind = FRAME_GOOD;
                else if (pick < 70) kind = FRAME_BAD_SUM;
                else if (pick < 79) kind = FRAME_BAD_COMPL;
                else if (pick < 87) kind = FRAME_SHORT;
                else if (pick < 94) kind = FRAME_LONG;
                else                kind = FRAME_NOISE;
                send_frame(kind, 8'($urandom), 8'($urandom), $urandom_range(1, 3), 1'b1);
            end
        end
    endtask

    initial begin : stimulus
        board = new();
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        s_tuser = cflw_pkg::FUNC_BYTE;
        items_sent = 0;
        gaps_on = 1'b1;
        sink_stalls = 1'b1;
        hold_requests = 0;
        mid_timeout = 8'($urandom_range(4, 254));

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: field extremes, each frame fault, ticks at reset timeout
        send_frame(FRAME_GOOD, 8'h00, 8'h00, 0, 1'b0);
        send_frame(FRAME_GOOD, 8'hff, 8'hff, 0, 1'b0);
        send_tick();
        send_frame(FRAME_SHORT, 8'h12, 8'h34, 0, 1'b0);
        send_frame(FRAME_LONG, 8'h56, 8'h78, 1, 1'b0);
        send_frame(FRAME_BAD_SUM, 8'h80, 8'h7f, 0, 1'b0);
        send_frame(FRAME_BAD_COMPL, 8'h7f, 8'h80, 0, 1'b0);

        // Zero timeout: every tick raises the link flag
        write_timeout(8'd0);
        send_tick();
        send_frame(FRAME_GOOD, 8'hc3, 8'h3c, 0, 1'b0);
        send_tick();

        // Good frame clears silence but the flag waits for the next tick
        write_timeout(8'd2);
        send_tick();
        send_tick();
        send_frame(FRAME_GOOD, 8'h05, 8'ha5, 0, 1'b0);
        send_tick();

        // Short timeout; receiver holds off while frames keep coming
        write_timeout(8'd3);
        gaps_on = 1'b0;
        hold_requests++;
        repeat (6) send_frame(FRAME_GOOD, 8'($urandom), 8'($urandom), 0, 1'b0);
        gaps_on = 1'b1;
        run_traffic(40);
        drain();
        send_frame(FRAME_LONG, 8'($urandom), 8'($urandom), 130, 1'b0);
        run_traffic(50);

        // Longest timeout: hold off good frames long enough to saturate silence
        write_timeout(8'd255);
        run_traffic(60);
        repeat (260) send_tick();
        run_traffic(30);

        write_timeout(mid_timeout);
        run_traffic(80);

        // Last part: one-second timeout and no idling on either side
        write_timeout(8'd1);
        gaps_on = 1'b0;
        sink_stalls = 1'b0;
        run_traffic(70);

        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("Sent %0d items: %0d good frames, %0d rejected frames, %0d ticks",
                 items_sent, board.good_frames, board.rejected_frames, board.ticks_seen);
        $display("Checked %0d results over link timeouts 120, 0, 2, 3, 255, %0d and 1; %0d lost",
                 board.results_checked, mid_timeout, board.lost_raised);
        if (board.errors == 0) begin
            $display("complement_frame_checker_link_watch_top test passed");
        end else begin
            $display("complement_frame_checker_link_watch_top test failed");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/cflw_pkg.sv
hw/rtl/cflw_core.sv
hw/rtl/complement_frame_checker_link_watch_top.sv
sim/tb_complement_frame_checker_link_watch_top.sv
